FILE: sv/csvfx_pkg.sv
// csvfx_pkg: shared types and character constants of the record field extractor
// no dependencies; imported by csvfx_parser, csvfx_emitter, the top level and the testbench
`default_nettype none

package csvfx_pkg;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;

    localparam int PREFIX_LEN = 4;
    localparam int MARK_LEN   = 13;
    localparam int BCD_DIGITS = 5;

    typedef enum logic [2:0] {
        PH_WAIT_CRLF = 3'd0,
        PH_SKIP_F1   = 3'd1,
        PH_TRIM_F2   = 3'd2,
        PH_COPY_F2   = 3'd3,
        PH_SKIP_F3   = 3'd4,
        PH_TRIM_F4   = 3'd5,
        PH_COPY_F4   = 3'd6,
        PH_WAIT_TARE = 3'd7
    } t_phase;

    typedef struct packed {
        logic start;
        logic flag;
        logic mark;
    } t_run;

endpackage

`default_nettype wire

FILE: sv/csvfx_line_ram.sv
// csvfx_line_ram: line character store, one write port and one registered read port
// no dependencies; instantiated by the top level
`default_nettype none

module csvfx_line_ram #(
    parameter int DEPTH = 48,
    parameter int AW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [7:0]    i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: sv/csvfx_parser.sv
// csvfx_parser: field parsing state machine, line length, record counters
// depends on csvfx_pkg; writes the line store, starts the emitter
`default_nettype none

module csvfx_parser #(
    parameter int LINE_BYTES = 48,
    parameter int LW         = 6
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [7:0]           i_data_byte,
    output logic                      o_ready,
    input  wire logic                 i_done,
    output logic                      o_wr_en,
    output logic      [LW-1:0]        o_wr_addr,
    output logic      [7:0]           o_wr_data,
    output csvfx_pkg::t_run           o_run,
    output logic      [LW-1:0]        o_len,
    output logic      [4*csvfx_pkg::BCD_DIGITS-1:0] o_bcd
);
    import csvfx_pkg::*;

    localparam logic [LW-1:0] CAP = LW'(LINE_BYTES - 1);
    localparam int BW = 4 * BCD_DIGITS;

    t_phase        r_phase, n_phase;
    logic [7:0]    r_prev;
    logic [LW-1:0] r_len, n_len;
    logic          r_ovf, n_ovf;
    logic [15:0]   r_cnt, n_cnt;
    logic [BW-1:0] r_bcd, n_bcd;
    logic          r_busy, n_busy;
    t_run          r_run, n_run;
    logic          acc;
    logic          put_en;
    logic [7:0]    put_ch;

    function automatic logic [BW-1:0] bcd_inc(input logic [BW-1:0] v);
        logic [BW-1:0] res;
        logic          carry;
        res   = v;
        carry = 1'b1;
        for (int k = 0; k < BCD_DIGITS; k++) begin
            if (carry) begin
                if (v[4*k +: 4] == 4'd9) begin
                    res[4*k +: 4] = 4'd0;
                end else begin
                    res[4*k +: 4] = v[4*k +: 4] + 4'd1;
                    carry         = 1'b0;
                end
            end
        end
        return res;
    endfunction

    assign acc = i_valid && !r_busy;

    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_ovf     = r_ovf;
        n_cnt     = r_cnt;
        n_bcd     = r_bcd;
        n_busy    = r_busy;
        n_run     = r_run;
        n_run.start = 1'b0;
        put_en    = 1'b0;
        put_ch    = i_data_byte;
        o_wr_en   = 1'b0;
        if (i_done) begin
            n_busy = 1'b0;
        end
        if (acc) begin
            case (r_phase)
                PH_WAIT_CRLF: begin
                    if (r_prev == CH_CR && i_data_byte == CH_LF) begin
                        n_len   = LW'(PREFIX_LEN);
                        n_ovf   = 1'b0;
                        n_phase = PH_SKIP_F1;
                    end
                end
                PH_SKIP_F1: begin
                    if (i_data_byte == CH_COMMA) begin
                        n_phase = PH_TRIM_F2;
                    end
                end
                PH_TRIM_F2, PH_COPY_F2: begin
                    if (i_data_byte == CH_COMMA) begin
                        put_en  = 1'b1;
                        put_ch  = CH_SPACE;
                        n_phase = PH_SKIP_F3;
                    end else if (r_phase == PH_COPY_F2 ||
                                 !(i_data_byte inside {CH_ZERO, CH_SPACE})) begin
                        put_en  = 1'b1;
                        n_phase = PH_COPY_F2;
                    end
                end
                PH_SKIP_F3: begin
                    if (i_data_byte == CH_COMMA) begin
                        n_phase = PH_TRIM_F4;
                    end
                end
                PH_TRIM_F4, PH_COPY_F4: begin
                    if (i_data_byte == CH_COMMA) begin
                        n_phase = PH_WAIT_TARE;
                    end else if (r_phase == PH_COPY_F4 ||
                                 !(i_data_byte inside {CH_ZERO, CH_SPACE})) begin
                        put_en  = 1'b1;
                        n_phase = PH_COPY_F4;
                    end
                end
                PH_WAIT_TARE: begin
                    if (i_data_byte inside {CH_ZERO, CH_ONE}) begin
                        n_phase = PH_WAIT_CRLF;
                        if (!r_ovf) begin
                            n_cnt       = r_cnt + 16'd1;
                            n_bcd       = (r_cnt == 16'hFFFF) ? '0 : bcd_inc(r_bcd);
                            n_busy      = 1'b1;
                            n_run.start = 1'b1;
                            n_run.flag  = (i_data_byte == CH_ONE);
                            n_run.mark  = (n_cnt[7:0] == 8'd0);
                        end
                    end
                end
                default: begin
                    n_phase = PH_WAIT_CRLF;
                end
            endcase
            if (put_en) begin
                if (r_len < CAP) begin
                    o_wr_en = 1'b1;
                    n_len   = r_len + LW'(1);
                end else begin
                    n_ovf = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT_CRLF;
            r_prev  <= 8'h00;
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_cnt   <= '0;
            r_bcd   <= '0;
            r_busy  <= 1'b0;
            r_run   <= '0;
        end else begin
            r_phase <= n_phase;
            if (acc) begin
                r_prev <= i_data_byte;
            end
            r_len  <= n_len;
            r_ovf  <= n_ovf;
            r_cnt  <= n_cnt;
            r_bcd  <= n_bcd;
            r_busy <= n_busy;
            r_run  <= n_run;
        end
    end

    assign o_ready   = !r_busy;
    assign o_wr_addr = r_len;
    assign o_wr_data = put_ch;
    assign o_run     = r_run;
    assign o_len     = r_len;
    assign o_bcd     = r_bcd;

`ifndef SYNTHESIS
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= CAP)
        else $error("line length beyond capacity");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run.start |-> r_busy)
        else $error("emission started without busy");
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_wr_en)
        else $error("line store written during emission");
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |-> r_busy && !r_run.start)
        else $error("emission done while idle");
`endif

endmodule

`default_nettype wire

FILE: sv/csvfx_emitter.sv
// csvfx_emitter: reads the line store and sends the line and sequence marker bytes
// depends on csvfx_pkg; fed by csvfx_parser and csvfx_line_ram
`default_nettype none

module csvfx_emitter #(
    parameter int LW = 6,
    parameter int PW = 6
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire csvfx_pkg::t_run      i_run,
    input  wire logic [LW-1:0]        i_len,
    input  wire logic [4*csvfx_pkg::BCD_DIGITS-1:0] i_bcd,
    output logic                      o_rd_en,
    output logic      [LW-1:0]        o_rd_addr,
    input  wire logic [7:0]           i_rd_data,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic      [7:0]           o_out_byte,
    output logic                      o_last_of_run,
    output logic                      o_done
);
    import csvfx_pkg::*;

    logic          r_active;
    logic [PW-1:0] r_pos;
    logic [PW-1:0] r_total;
    logic [PW-1:0] r_len;
    logic          r_flag;
    logic          r_fetch_v;
    logic [PW-1:0] r_fetch_pos;
    logic          r_fetch_last;
    logic          r_out_v;
    logic [7:0]    r_out_byte;
    logic          r_out_last;
    logic          issue;
    logic          issue_last;
    logic [PW-1:0] mark_off;
    logic [3:0]    mark_idx;
    logic [7:0]    sel_byte;

    function automatic logic [7:0] seq_char(input logic [2:0] idx);
        case (idx)
            3'd0:    return CH_CR;
            3'd1:    return CH_LF;
            3'd2:    return 8'h53;
            3'd3:    return 8'h65;
            3'd4:    return 8'h71;
            3'd5:    return 8'h23;
            default: return 8'h2E;
        endcase
    endfunction

    assign issue      = r_active && !r_fetch_v && (!r_out_v || i_ready);
    assign issue_last = (r_pos == r_total - PW'(1));
    assign o_rd_en    = issue && (r_pos >= PW'(PREFIX_LEN)) && (r_pos < r_len);
    assign o_rd_addr  = r_pos[LW-1:0];

    assign mark_off = r_fetch_pos - r_len;
    assign mark_idx = mark_off[3:0];

    always_comb begin
        if (r_fetch_pos < PW'(PREFIX_LEN)) begin
            case (r_fetch_pos[1:0])
                2'd0:    sel_byte = CH_CR;
                2'd1:    sel_byte = CH_LF;
                2'd2:    sel_byte = r_flag ? CH_ONE : CH_ZERO;
                default: sel_byte = CH_SPACE;
            endcase
        end else if (r_fetch_pos < r_len) begin
            sel_byte = i_rd_data;
        end else if (mark_idx < 4'd8) begin
            sel_byte = seq_char(mark_idx[2:0]);
        end else begin
            case (mark_idx)
                4'd8:    sel_byte = CH_ZERO + {4'd0, i_bcd[19:16]};
                4'd9:    sel_byte = CH_ZERO + {4'd0, i_bcd[15:12]};
                4'd10:   sel_byte = CH_ZERO + {4'd0, i_bcd[11:8]};
                4'd11:   sel_byte = CH_ZERO + {4'd0, i_bcd[7:4]};
                default: sel_byte = CH_ZERO + {4'd0, i_bcd[3:0]};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_fetch_v <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            if (i_run.start) begin
                r_active <= 1'b1;
            end else if (issue && issue_last) begin
                r_active <= 1'b0;
            end
            r_fetch_v <= issue;
            if (r_fetch_v) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_run.start) begin
            r_pos   <= '0;
            r_len   <= PW'(i_len);
            r_total <= PW'(i_len) + (i_run.mark ? PW'(MARK_LEN) : PW'(0));
            r_flag  <= i_run.flag;
        end else if (issue) begin
            r_pos <= r_pos + PW'(1);
        end
        if (issue) begin
            r_fetch_pos  <= r_pos;
            r_fetch_last <= issue_last;
        end
        if (r_fetch_v) begin
            r_out_byte <= sel_byte;
            r_out_last <= r_fetch_last;
        end
    end

    assign o_valid       = r_out_v;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_done        = r_out_v && i_ready && r_out_last;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fetch_v |-> !issue)
        else $error("read issued with fetch in flight");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fetch_v |-> !r_out_v)
        else $error("output register overwritten");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_run.start |-> !r_active && !r_fetch_v && !r_out_v)
        else $error("new run while emitting");
`endif

endmodule

`default_nettype wire

FILE: sv/csv_record_field_extractor.sv
// csv_record_field_extractor: top level of the serial record field extractor
// depends on csvfx_pkg, csvfx_line_ram, csvfx_parser and csvfx_emitter
//
// Input channel i_valid/o_ready carries one received byte per request in
// i_data_byte. Output channel o_valid/i_ready carries one character per request
// in o_out_byte; o_last_of_run marks the final character caused by one input.
// Parsing bytes, taken one per cycle while o_ready is high, produce nothing.
// The tare byte that ends a record starts a run of the line (prefix CR LF flag
// space, then the copied fields) and, on every 256th record, CR LF "Seq#.."
// with five digits; no run starts if the line overflowed the store. Each run
// byte passes the fetch register, which takes the line store read, and then the
// output register; the next byte is issued once the fetch register is free.
// o_ready stays low from the tare byte until the last byte of the run is taken.
// A stalled receiver simply holds the current byte in the output register.
// Reset (i_rst_n low, synchronous) waits for CR LF, clears the record count and
// drops any run in progress; the line store needs no clearing.
`default_nettype none

module csv_record_field_extractor #(
    parameter int LINE_BYTES = 48
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic      [7:0] o_out_byte,
    output logic            o_last_of_run
);
    import csvfx_pkg::*;

    localparam int LW = $clog2(LINE_BYTES);
    localparam int PW = $clog2(LINE_BYTES + MARK_LEN);

    logic                    wr_en;
    logic [LW-1:0]           wr_addr;
    logic [7:0]              wr_data;
    logic                    rd_en;
    logic [LW-1:0]           rd_addr;
    logic [7:0]              rd_data;
    t_run                    run;
    logic [LW-1:0]           len;
    logic [4*BCD_DIGITS-1:0] bcd;
    logic                    done;

    csvfx_line_ram #(
        .DEPTH (LINE_BYTES),
        .AW    (LW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    csvfx_parser #(
        .LINE_BYTES (LINE_BYTES),
        .LW         (LW)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .o_ready     (o_ready),
        .i_done      (done),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_run       (run),
        .o_len       (len),
        .o_bcd       (bcd)
    );

    csvfx_emitter #(
        .LW (LW),
        .PW (PW)
    ) u_emitter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_run         (run),
        .i_len         (len),
        .i_bcd         (bcd),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_done        (done)
    );

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// testbench: self-checking bench for csv_record_field_extractor
// depends on csvfx_pkg and the extractor RTL; predicts each rebuilt line byte
// in a local model of the parser and compares every output character in order

module testbench;
    import csvfx_pkg::*;

    localparam int LINE_BYTES = 48;
    localparam int LINE_CAP = LINE_BYTES - 1;
    localparam int SINK_HOLD_CYCLES = 200;
    localparam int RANDOM_ITEMS = 40;
    localparam int DRAIN_CYCLES = 150;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_exp;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_data_byte;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;

    // line model state
    t_phase      parse_state = PH_WAIT_CRLF;
    logic [7:0]  prev_byte = 8'h00;
    logic [7:0]  line_chars [LINE_BYTES];
    int          line_len = 0;
    bit          line_ovf = 1'b0;
    logic [15:0] rec_count = 16'd0;

    t_char_exp  char_q[$];
    logic [7:0] rec_bytes[$];

    bit quiet_tail = 1'b0;
    bit sink_hold_req = 1'b0;
    int err_count = 0;
    int chars_checked = 0;
    int bytes_sent = 0;
    int lines_dropped = 0;
    int seq_marks = 0;

    csv_record_field_extractor #(
        .LINE_BYTES(LINE_BYTES)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_last_of_run(o_last_of_run)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void store_char(input logic [7:0] c);
        if (line_len < LINE_CAP) begin
            line_chars[line_len] = c;
            line_len++;
        end else begin
            line_ovf = 1'b1;
        end
    endfunction

    function automatic void close_record(input logic [7:0] tare);
        t_char_exp  run_q[$];
        t_char_exp  e;
        logic [7:0] digits [5];
        string      tag = "Seq#..";
        int         v;
        parse_state = PH_WAIT_CRLF;
        if (line_ovf) begin
            lines_dropped++;
            return;
        end
        if (tare == CH_ONE && 2 < line_len)
            line_chars[2] = CH_ONE;
        for (int i = 0; i < line_len; i++) begin
            e.ch = line_chars[i];
            e.last = 1'b0;
            run_q.push_back(e);
        end
        rec_count = rec_count + 16'd1;
        if (rec_count[7:0] == 8'd0) begin
            seq_marks++;
            e.last = 1'b0;
            e.ch = CH_CR;
            run_q.push_back(e);
            e.ch = CH_LF;
            run_q.push_back(e);
            for (int i = 0; i < 6; i++) begin
                e.ch = tag[i];
                run_q.push_back(e);
            end
            v = rec_count;
            for (int i = 0; i < 5; i++) begin
                digits[4 - i] = CH_ZERO + 8'(v % 10);
                v = v / 10;
            end
            for (int i = 0; i < 5; i++) begin
                e.ch = digits[i];
                run_q.push_back(e);
            end
        end
        if (run_q.size() > 0)
            run_q[run_q.size() - 1].last = 1'b1;
        foreach (run_q[i])
            char_q.push_back(run_q[i]);
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        case (parse_state)
            PH_WAIT_CRLF: begin
                if (prev_byte == CH_CR && b == CH_LF) begin
                    line_len = 0;
                    line_ovf = 1'b0;
                    store_char(CH_CR);
                    store_char(CH_LF);
                    store_char(CH_ZERO);
                    store_char(CH_SPACE);
                    parse_state = PH_SKIP_F1;
                end
            end
            PH_SKIP_F1: begin
                if (b == CH_COMMA)
                    parse_state = PH_TRIM_F2;
            end
            PH_TRIM_F2: begin
                if (b == CH_COMMA) begin
                    store_char(CH_SPACE);
                    parse_state = PH_SKIP_F3;
                end else if (b != CH_ZERO && b != CH_SPACE) begin
                    store_char(b);
                    parse_state = PH_COPY_F2;
                end
            end
            PH_COPY_F2: begin
                if (b == CH_COMMA) begin
                    store_char(CH_SPACE);
                    parse_state = PH_SKIP_F3;
                end else begin
                    store_char(b);
                end
            end
            PH_SKIP_F3: begin
                if (b == CH_COMMA)
                    parse_state = PH_TRIM_F4;
            end
            PH_TRIM_F4: begin
                if (b == CH_COMMA) begin
                    parse_state = PH_WAIT_TARE;
                end else if (b != CH_ZERO && b != CH_SPACE) begin
                    store_char(b);
                    parse_state = PH_COPY_F4;
                end
            end
            PH_COPY_F4: begin
                if (b == CH_COMMA)
                    parse_state = PH_WAIT_TARE;
                else
                    store_char(b);
            end
            default: begin
                if (b == CH_ZERO || b == CH_ONE)
                    close_record(b);
            end
        endcase
        prev_byte = b;
    endfunction

    function automatic logic [7:0] rand_field_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_COMMA);
        return c;
    endfunction

    function automatic logic [7:0] rand_tare_noise();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_ZERO || c == CH_ONE);
        return c;
    endfunction

    function automatic void build_record(input int max_body);
        rec_bytes.delete();
        rec_bytes.push_back(CH_CR);
        rec_bytes.push_back(CH_LF);
        repeat ($urandom_range(0, 3)) rec_bytes.push_back(rand_field_char());
        rec_bytes.push_back(CH_COMMA);
        repeat ($urandom_range(0, 3))
            rec_bytes.push_back($urandom_range(0, 1) ? CH_ZERO : CH_SPACE);
        repeat ($urandom_range(0, max_body)) rec_bytes.push_back(rand_field_char());
        rec_bytes.push_back(CH_COMMA);
        repeat ($urandom_range(0, 3)) rec_bytes.push_back(rand_field_char());
        rec_bytes.push_back(CH_COMMA);
        repeat ($urandom_range(0, 3))
            rec_bytes.push_back($urandom_range(0, 1) ? CH_ZERO : CH_SPACE);
        repeat ($urandom_range(0, max_body)) rec_bytes.push_back(rand_field_char());
        rec_bytes.push_back(CH_COMMA);
        repeat ($urandom_range(0, 2)) rec_bytes.push_back(rand_tare_noise());
        rec_bytes.push_back($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do
            @(posedge i_clk);
        while (!o_ready);
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_record_bytes(input int count);
        for (int i = 0; i < count && i < rec_bytes.size(); i++)
            send_byte(rec_bytes[i]);
    endtask

    task automatic start_line();
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    // walk any parse phase back to waiting for a line start
    task automatic resync();
        send_text(",,,,0");
    endtask

    task automatic test_record_basics();
        start_line();
        send_text("7,0 042,x,  9,q1");
        start_line();
        send_text(",,,,0");
        start_line();
        send_text("a,000, ,00,1");
    endtask

    task automatic test_framing_extremes();
        send_byte(CH_CR);
        send_byte(8'h78);
        send_byte(CH_LF);
        send_text("A,B,C,D,1");
        send_byte(CH_CR);
        start_line();
        send_byte(8'hFF);
        send_byte(CH_COMMA);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_COMMA);
        send_byte(CH_CR);
        send_byte(CH_COMMA);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(CH_COMMA);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_ZERO);
    endtask

    task automatic send_sized_line(input int f2_len, input int f4_len, input logic [7:0] tare);
        start_line();
        send_text("k,");
        repeat (f2_len) send_byte(8'h41);
        send_text(",z,");
        repeat (f4_len) send_byte(8'h42);
        send_byte(CH_COMMA);
        send_byte(tare);
    endtask

    task automatic test_line_overflow();
        resync();
        send_sized_line(30, 12, CH_ONE);
        send_sized_line(30, 13, CH_ZERO);
        send_sized_line(44, 4, CH_ONE);
        start_line();
        send_text("1,5,,6,0");
    endtask

    task automatic test_output_backpressure();
        resync();
        sink_hold_req = 1'b1;
        repeat (2) begin
            build_record(12);
            send_record_bytes(rec_bytes.size());
        end
    endtask

    task automatic test_random_records();
        int stop_at;
        int pick;
        stop_at = bytes_sent + RANDOM_ITEMS;
        resync();
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                build_record(8);
                send_record_bytes(rec_bytes.size());
            end else if (pick < 75) begin
                build_record(28);
                send_record_bytes(rec_bytes.size());
            end else if (pick < 90) begin
                build_record(8);
                send_record_bytes($urandom_range(1, rec_bytes.size() - 1));
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_quiet_tail();
        resync();
        quiet_tail = 1'b1;
        repeat (3) begin
            build_record(6);
            send_record_bytes(rec_bytes.size());
        end
    endtask

    // sink pacing: random short stalls, one long hold on request
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES - 1) @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_char_exp want;
        if (i_rst_n && o_valid && i_ready) begin
            if (char_q.size() == 0) begin
                $display("%0t: unexpected character: expected none, actual %h last %b",
                         $time, o_out_byte, o_last_of_run);
                err_count++;
            end else begin
                want = char_q.pop_front();
                chars_checked++;
                if (o_out_byte !== want.ch) begin
                    $display("%0t: out_byte mismatch: expected %h, actual %h",
                             $time, want.ch, o_out_byte);
                    err_count++;
                end
                if (o_last_of_run !== want.last) begin
                    $display("%0t: last_of_run mismatch: expected %b, actual %b",
                             $time, want.last, o_last_of_run);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d characters outstanding", char_q.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_data_byte <= 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_record_basics();
        test_framing_extremes();
        test_line_overflow();
        test_output_backpressure();
        test_random_records();
        test_quiet_tail();

        i_valid <= 1'b0;
        while (char_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d bytes: %0d records emitted, %0d long lines dropped, %0d seq marks",
                 bytes_sent, rec_count, lines_dropped, seq_marks);
        $display("compared %0d output characters", chars_checked);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", err_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
